// ===== hw/rtl/kwh_pkg.sv =====
// Package for the keyword highlighting lexer.
// Holds lexical mode codes, character constants and the identifier test.
// No dependencies.
package kwh_pkg;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_CHAR   = 3'd1;
  localparam logic [2:0] MODE_STRING = 3'd2;
  localparam logic [2:0] MODE_LINE   = 3'd3;
  localparam logic [2:0] MODE_BLOCK  = 3'd4;

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_NL     = 8'h0a;

  function automatic logic is_boundary(input logic [7:0] c);
    logic ident;
    ident = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
            (c >= 8'h61 && c <= 8'h7a) || (c == CH_USCORE);
    return !ident;
  endfunction

endpackage

// ===== hw/rtl/kwh_table.sv =====
// Keyword table memory: one byte written per cycle, one whole row read.
// Read data is registered. Depends on nothing.
module kwh_table #(
  parameter int NUM_KEYWORDS    = 64,
  parameter int MAX_KEYWORD_LEN = 16,
  parameter int SLOT_W          = 6,
  parameter int OFF_W           = 4
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [SLOT_W-1:0]            wr_slot,
  input  logic [OFF_W-1:0]             wr_off,
  input  logic [7:0]                   wr_data,
  input  logic [SLOT_W-1:0]            rd_slot,
  output logic [MAX_KEYWORD_LEN*8-1:0] rd_row
);

  // One row per keyword slot; a write touches a single byte lane of its row.
  logic [MAX_KEYWORD_LEN*8-1:0] mem [NUM_KEYWORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot][wr_off*8 +: 8] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_row <= mem[rd_slot];
  end

endmodule

// ===== hw/rtl/kwh_match.sv =====
// Compares one keyword row against the lookahead window in parallel.
// Depends on kwh_pkg for the identifier test.
module kwh_match #(
  parameter int MAX_KEYWORD_LEN = 16,
  parameter int LEN_W           = 5
) (
  input  logic [MAX_KEYWORD_LEN*8-1:0]     row,
  input  logic [(MAX_KEYWORD_LEN+1)*8-1:0] win,
  output logic                             hit,
  output logic [LEN_W-1:0]                 len
);
  import kwh_pkg::*;

  logic             found0;
  logic             eq;
  logic [7:0]       after;

  always_comb begin
    len    = LEN_W'(MAX_KEYWORD_LEN);
    found0 = 1'b0;
    for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
      if (!found0 && row[j*8 +: 8] == 8'h00) begin
        len    = LEN_W'(j);
        found0 = 1'b1;
      end
    end
    eq    = 1'b1;
    after = 8'h00;
    for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
      if (LEN_W'(j) < len && row[j*8 +: 8] != win[j*8 +: 8]) begin
        eq = 1'b0;
      end
    end
    for (int j = 0; j <= MAX_KEYWORD_LEN; j++) begin
      if (LEN_W'(j) == len) begin
        after = win[j*8 +: 8];
      end
    end
    hit = (len != '0) && eq && is_boundary(after);
  end

endmodule

// ===== hw/rtl/keyword_highlight_lexer.sv =====
// Top level of the keyword highlighting lexer: sequencer, window and state.
// Depends on kwh_pkg, kwh_table and kwh_match.
//
// Input items carry either a text byte or a keyword table byte write
// (in_req_type high). A table write gives no result.
// Text bytes enter a lookahead window of MAX_KEYWORD_LEN+1 bytes; once the
// window is full each text item releases the byte at its head, and an item
// with in_end_of_text releases the whole window, the final byte with
// out_last set. The block is not ready while it works on an item.
// A text item that releases nothing still keeps in_ready low while it is checked.
// Releasing one byte passes through the CHECK and EMIT states. A byte examined in
// normal mode after a boundary is first searched against min(keyword_count,
// NUM_KEYWORDS) slots: the first slot is issued, then each slot is compared in
// turn in the shared comparator until the first hit or the last slot.
// A result waits in the output register while out_ready is low, and the
// sequencer waits with it. cfg_we writes keyword_count at once.
// Reset clears window, mode and count; the table is undefined until written.
module keyword_highlight_lexer #(
  parameter int NUM_KEYWORDS    = 64,
  parameter int MAX_KEYWORD_LEN = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [7:0] in_data_byte,
  input  logic [5:0] in_keyword_slot,
  input  logic [3:0] in_keyword_offset,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_highlighted,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);
  import kwh_pkg::*;

  localparam int WIN    = MAX_KEYWORD_LEN + 1;
  localparam int SLOT_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
  localparam int CNT_W  = $clog2(NUM_KEYWORDS + 1);
  localparam int OFF_W  = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;
  localparam int LEN_W  = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int FILL_W = $clog2(WIN + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [6:0]         kcount_r;
  logic [WIN*8-1:0]   win_r, win_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic               odd_r, odd_nxt;
  logic [7:0]         prev_r, prev_nxt;
  logic [LEN_W-1:0]   hlrem_r, hlrem_nxt;
  logic               pend_r, pend_nxt;
  logic               eot_r, eot_nxt;
  logic [CNT_W-1:0]   rdslot_r, rdslot_nxt;
  logic               cmpv_r, cmpv_nxt;
  logic [LEN_W-1:0]   flen_r, flen_nxt;
  logic               outv_r, outv_nxt;
  logic [7:0]         obyte_r, obyte_nxt;
  logic               ohl_r, ohl_nxt;
  logic               olast_r, olast_nxt;

  logic [CNT_W-1:0]   cnt_eff;
  logic [MAX_KEYWORD_LEN*8-1:0] row;
  logic               m_hit;
  logic [LEN_W-1:0]   m_len;
  logic               tbl_we;
  logic               in_acc;
  logic [7:0]         c, nx;
  logic               hl;

  assign cnt_eff = (32'(kcount_r) > NUM_KEYWORDS) ? CNT_W'(NUM_KEYWORDS)
                                                  : CNT_W'(kcount_r);
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign tbl_we   = in_acc && in_req_type &&
                    (32'(in_keyword_slot) < NUM_KEYWORDS) &&
                    (32'(in_keyword_offset) < MAX_KEYWORD_LEN);

  kwh_table #(
    .NUM_KEYWORDS(NUM_KEYWORDS), .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN),
    .SLOT_W(SLOT_W), .OFF_W(OFF_W)
  ) u_table (
    .clk(clk), .wr_en(tbl_we),
    .wr_slot(SLOT_W'(32'(in_keyword_slot))),
    .wr_off(OFF_W'(32'(in_keyword_offset))),
    .wr_data(in_data_byte),
    .rd_slot(rdslot_r[SLOT_W-1:0]),
    .rd_row(row)
  );

  kwh_match #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN), .LEN_W(LEN_W)) u_match (
    .row(row), .win(win_r), .hit(m_hit), .len(m_len)
  );

  assign c  = win_r[7:0];
  assign nx = win_r[15:8];

  always_comb begin
    state_nxt  = state_r;
    win_nxt    = win_r;
    fill_nxt   = fill_r;
    mode_nxt   = mode_r;
    odd_nxt    = odd_r;
    prev_nxt   = prev_r;
    hlrem_nxt  = hlrem_r;
    pend_nxt   = pend_r;
    eot_nxt    = eot_r;
    rdslot_nxt = rdslot_r;
    cmpv_nxt   = cmpv_r;
    flen_nxt   = flen_r;
    outv_nxt   = outv_r && !out_ready;
    obyte_nxt  = obyte_r;
    ohl_nxt    = ohl_r;
    olast_nxt  = olast_r;
    hl         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !in_req_type) begin
          for (int i = 0; i < WIN; i++) begin
            if (FILL_W'(i) == fill_r) begin
              win_nxt[i*8 +: 8] = in_data_byte;
            end
          end
          fill_nxt  = fill_r + 1'b1;
          eot_nxt   = in_end_of_text;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        flen_nxt = '0;
        if (eot_r ? (fill_r != '0) : (fill_r == FILL_W'(WIN))) begin
          if (hlrem_r == '0 && !pend_r && mode_r == MODE_NORMAL &&
              is_boundary(prev_r) && cnt_eff != '0) begin
            rdslot_nxt = '0;
            cmpv_nxt   = 1'b0;
            state_nxt  = S_SEARCH;
          end else begin
            state_nxt = S_EMIT;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SEARCH: begin
        // Rows arrive in the cycle after their slot is issued; first hit wins.
        if (cmpv_r && m_hit) begin
          flen_nxt  = m_len;
          state_nxt = S_EMIT;
        end else if (rdslot_r < cnt_eff) begin
          rdslot_nxt = rdslot_r + 1'b1;
          cmpv_nxt   = 1'b1;
        end else if (!cmpv_r || rdslot_r == cnt_eff) begin
          if (!cmpv_r) begin
            state_nxt = S_EMIT;
          end
          cmpv_nxt = 1'b0;
        end
      end
      S_EMIT: begin
        if (!outv_r || out_ready) begin
          priority if (hlrem_r != '0) begin
            hl        = 1'b1;
            hlrem_nxt = hlrem_r - 1'b1;
          end else if (pend_r) begin
            pend_nxt = 1'b0;
          end else if (mode_r == MODE_CHAR) begin
            if (!odd_r && c == CH_QUOTE) mode_nxt = MODE_NORMAL;
          end else if (mode_r == MODE_STRING) begin
            if (!odd_r && c == CH_DQUOTE) mode_nxt = MODE_NORMAL;
          end else if (mode_r == MODE_LINE) begin
            if (c == CH_NL) mode_nxt = MODE_NORMAL;
          end else if (mode_r == MODE_BLOCK) begin
            if (c == CH_STAR && nx == CH_SLASH) begin
              mode_nxt = MODE_NORMAL;
              pend_nxt = 1'b1;
            end
          end else begin
            if (c == CH_QUOTE) mode_nxt = MODE_CHAR;
            else if (c == CH_DQUOTE) mode_nxt = MODE_STRING;
            else if (c == CH_SLASH && nx == CH_SLASH) mode_nxt = MODE_LINE;
            else if (c == CH_SLASH && nx == CH_STAR) mode_nxt = MODE_BLOCK;
            if (flen_r != '0) begin
              mode_nxt  = MODE_NORMAL;
              hl        = 1'b1;
              hlrem_nxt = flen_r - 1'b1;
            end
          end
          outv_nxt  = 1'b1;
          obyte_nxt = c;
          ohl_nxt   = hl;
          olast_nxt = eot_r && (fill_r == FILL_W'(1));
          odd_nxt   = (c == CH_BSLASH) ? !odd_r : 1'b0;
          prev_nxt  = c;
          win_nxt   = win_r >> 8;
          fill_nxt  = fill_r - 1'b1;
          state_nxt = S_CHECK;
          if (eot_r && fill_r == FILL_W'(1)) begin
            // The text is over: the lexer starts afresh for the next one.
            win_nxt   = '0;
            fill_nxt  = '0;
            mode_nxt  = MODE_NORMAL;
            odd_nxt   = 1'b0;
            prev_nxt  = 8'h00;
            hlrem_nxt = '0;
            pend_nxt  = 1'b0;
            eot_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      kcount_r <= '0;
      win_r    <= '0;
      fill_r   <= '0;
      mode_r   <= MODE_NORMAL;
      odd_r    <= 1'b0;
      prev_r   <= 8'h00;
      hlrem_r  <= '0;
      pend_r   <= 1'b0;
      eot_r    <= 1'b0;
      rdslot_r <= '0;
      cmpv_r   <= 1'b0;
      flen_r   <= '0;
      outv_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) kcount_r <= cfg_wdata;
      win_r    <= win_nxt;
      fill_r   <= fill_nxt;
      mode_r   <= mode_nxt;
      odd_r    <= odd_nxt;
      prev_r   <= prev_nxt;
      hlrem_r  <= hlrem_nxt;
      pend_r   <= pend_nxt;
      eot_r    <= eot_nxt;
      rdslot_r <= rdslot_nxt;
      cmpv_r   <= cmpv_nxt;
      flen_r   <= flen_nxt;
      outv_r   <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    ohl_r   <= ohl_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = outv_r;
  assign out_byte        = obyte_r;
  assign out_highlighted = ohl_r;
  assign out_last        = olast_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WIN)) else $error("window fill beyond window length");

  a_hl_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (hlrem_r != '0) |-> (mode_r == MODE_NORMAL))
    else $error("keyword highlight running outside normal mode");

  a_pend_normal: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (mode_r == MODE_NORMAL && hlrem_r == '0))
    else $error("comment close pending in wrong state");

  a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && state_nxt == S_IDLE) |=> (fill_r == '0 && out_last))
    else $error("end of text left bytes in the window");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for keyword_highlight_lexer.
// Holds a scoreboard class that predicts the released bytes and their highlight flags.
// Depends on kwh_pkg and the keyword_highlight_lexer RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kwh_pkg::*;

  localparam int NKW    = 64;
  localparam int KWLEN  = 16;
  localparam int WLEN   = KWLEN + 1;
  localparam int LIMIT  = 1500000;

  typedef struct packed {
    logic [7:0] data;
    logic       hl;
    logic       last;
  } lex_byte_t;

  class highlight_scoreboard;
    logic [7:0] kw_mem [NKW*KWLEN];
    logic [7:0] win [WLEN];
    int         fill;
    logic [2:0] mode;
    logic       odd_bs;
    logic [7:0] prev;
    int         hl_left;
    logic       slash_pend;
    int         kw_count;
    lex_byte_t  pending_q [$];
    int         errors;

    function new();
      foreach (kw_mem[i]) kw_mem[i] = 8'h00;
      kw_count = 0;
      errors   = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (win[i]) win[i] = 8'h00;
      fill = 0; mode = MODE_NORMAL; odd_bs = 0; prev = 8'h00;
      hl_left = 0; slash_pend = 0;
    endfunction

    function bit non_ident(logic [7:0] c);
      return !((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == CH_USCORE);
    endfunction

    function logic [7:0] peek(int i);
      return (i < fill) ? win[i] : 8'h00;
    endfunction

    function int kw_len(int s);
      int n;
      n = 0;
      while (n < KWLEN && kw_mem[s*KWLEN+n] != 8'h00) n++;
      return n;
    endfunction

    function int match_len();
      int lim, n, j;
      lim = (kw_count > NKW) ? NKW : kw_count;
      if (!non_ident(prev)) return 0;
      for (int s = 0; s < lim; s++) begin
        n = kw_len(s);
        if (n == 0) continue;
        for (j = 0; j < n; j++)
          if (kw_mem[s*KWLEN+j] != peek(j)) break;
        if (j == n && non_ident(peek(n))) return n;
      end
      return 0;
    endfunction

    function void release_head(bit is_last);
      logic [7:0] c, nx;
      logic       hl;
      int         n;
      lex_byte_t  r;
      c = win[0]; nx = peek(1); hl = 0;
      if (hl_left > 0) begin
        hl = 1; hl_left--;
      end else if (slash_pend) begin
        slash_pend = 0;
      end else if (mode == MODE_CHAR) begin
        if (!odd_bs && c == CH_QUOTE) mode = MODE_NORMAL;
      end else if (mode == MODE_STRING) begin
        if (!odd_bs && c == CH_DQUOTE) mode = MODE_NORMAL;
      end else if (mode == MODE_LINE) begin
        if (c == CH_NL) mode = MODE_NORMAL;
      end else if (mode == MODE_BLOCK) begin
        if (c == CH_STAR && nx == CH_SLASH) begin
          mode = MODE_NORMAL; slash_pend = 1;
        end
      end else begin
        if (c == CH_QUOTE) mode = MODE_CHAR;
        else if (c == CH_DQUOTE) mode = MODE_STRING;
        else if (c == CH_SLASH && nx == CH_SLASH) mode = MODE_LINE;
        else if (c == CH_SLASH && nx == CH_STAR) mode = MODE_BLOCK;
        n = match_len();
        if (n > 0) begin
          mode = MODE_NORMAL; hl = 1; hl_left = n - 1;
        end
      end
      r.data = c; r.hl = hl; r.last = is_last;
      pending_q.push_back(r);
      odd_bs = (c == CH_BSLASH) ? !odd_bs : 1'b0;
      prev = c;
      for (int i = 0; i < WLEN-1; i++) win[i] = win[i+1];
      win[WLEN-1] = 8'h00;
      if (fill > 0) fill--;
    endfunction

    function void note_input(logic req, logic [7:0] b, logic [5:0] slot,
                             logic [3:0] off, logic eot);
      if (req) begin
        kw_mem[slot*KWLEN+off] = b;
        return;
      end
      while (fill >= WLEN) release_head(0);
      win[fill] = b;
      fill++;
      if (eot) begin
        while (fill > 0) release_head(fill == 1);
        clear_text();
      end else begin
        while (fill >= WLEN) release_head(0);
      end
    endfunction

    function void check_result(logic [7:0] b, logic hl, logic last);
      lex_byte_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result byte %h hl %b last %b", $time, b, hl, last);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (e.data !== b) begin
        $display("%0t: out_byte expected %h actual %h", $time, e.data, b); errors++;
      end
      if (e.hl !== hl) begin
        $display("%0t: out_highlighted expected %b actual %b", $time, e.hl, hl); errors++;
      end
      if (e.last !== last) begin
        $display("%0t: out_last expected %b actual %b", $time, e.last, last); errors++;
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_ready;
  logic       in_req_type = 0;
  logic [7:0] in_data_byte = 0;
  logic [5:0] in_keyword_slot = 0;
  logic [3:0] in_keyword_offset = 0;
  logic       in_end_of_text = 0;
  logic       out_valid;
  logic       out_ready = 0;
  logic [7:0] out_byte;
  logic       out_highlighted;
  logic       out_last;
  logic       cfg_we = 0;
  logic [6:0] cfg_wdata = 0;

  highlight_scoreboard sb = new();
  int cycles = 0;
  int hold_req = 0;

  keyword_highlight_lexer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_data_byte(in_data_byte), .in_keyword_slot(in_keyword_slot),
    .in_keyword_offset(in_keyword_offset), .in_end_of_text(in_end_of_text),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_highlighted(out_highlighted), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stalls, mostly short, and a long hold-off on request.
  initial begin
    int run_left;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_byte, out_highlighted, out_last);
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        hold_req--;
      end else if (run_left > 0) begin
        run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
        run_left = $urandom_range(0, 30);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic req, logic [7:0] b, logic [5:0] slot,
                           logic [3:0] off, logic eot, bit gaps = 1);
    int gap;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_data_byte      <= b;
    in_keyword_slot   <= slot;
    in_keyword_offset <= off;
    in_end_of_text    <= eot;
    do @(posedge clk); while (!in_ready);
    sb.note_input(req, b, slot, off, eot);
  endtask

  // Writes the keyword bytes and its terminator; a full-length keyword has none.
  task automatic load_keyword(int slot, string kw);
    for (int i = 0; i < KWLEN && i <= kw.len(); i++)
      send_item(1'b1, (i < kw.len()) ? kw[i] : 8'h00, 6'(slot), 4'(i), 1'b0, 0);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_item(1'b0, s[i], 6'($urandom), 4'($urandom), i == s.len() - 1);
  endtask

  // Waits for every expected byte, then lets the sequencer settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_count(logic [6:0] v);
    in_valid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.kw_count = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic string rand_keyword();
    string s;
    int n;
    byte letters [5] = '{"a", "b", "c", "i", "f"};
    s = "";
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) s = {s, string'(letters[$urandom_range(0, 4)])};
    return s;
  endfunction

  function automatic logic [7:0] rand_text_byte();
    byte pool [14] = '{"a", "b", "c", "i", "f", " ", "'", "\"", "\\", "/", "*",
                       "\n", "_", "1"};
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return pool[$urandom_range(0, 13)];
  endfunction

  initial begin
    int phase_len, left;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slots past the directed keywords hold a terminator only, so that no search
    // ever reads an unwritten byte.
    load_keyword(0, "int");
    load_keyword(1, "if");
    load_keyword(2, "a");
    load_keyword(3, "");
    load_keyword(4, "abcabcabcabcabca");
    load_keyword(5, "a_1");
    for (int s = 6; s < NKW; s++) load_keyword(s, "");

    // With no slots in use nothing is highlighted.
    send_text("if a");
    drain();
    set_count(7'd64);

    // Directed: keywords at boundaries, literals with escapes, comments,
    // the slash-star-slash case, a full-length keyword and extreme bytes.
    send_text("int(a_1)'\\'if'if");
    send_text("\"\\\\\"a//if\na");
    send_text("/*/a*/a");
    send_text("abcabcabcabcabca");
    send_item(1'b0, 8'h00, 6'h3f, 4'hf, 1'b0);
    send_item(1'b0, 8'hff, 6'h00, 4'h0, 1'b1);
    drain();

    for (int ph = 0; ph < 2; ph++) begin
      case (ph)
        0: set_count(7'd127);
        default: set_count(7'($urandom_range(1, 64)));
      endcase
      if (ph == 1) load_keyword(6, rand_keyword());
      // The long hold-off runs while one text longer than the window is offered.
      if (ph == 0) hold_req = 300;
      left = (ph == 0) ? 20 : 6;
      while (left > 0) begin
        phase_len = (ph == 0) ? left : $urandom_range(1, 6);
        if (phase_len > left) phase_len = left;
        for (int i = 0; i < phase_len; i++)
          send_item(1'b0, rand_text_byte(), 6'($urandom), 4'($urandom),
                    i == phase_len - 1);
        left -= phase_len;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/kwh_pkg.sv
hw/rtl/kwh_table.sv
hw/rtl/kwh_match.sv
hw/rtl/keyword_highlight_lexer.sv
verif/tb.sv
